// ===== hdl/mtne_pkg.sv =====
`default_nettype none

package mtne_pkg;

    localparam logic [7:0] META_STATUS    = 8'hFF;
    localparam logic [7:0] SYSEX_START    = 8'hF0;
    localparam logic [7:0] SYSEX_ESCAPE   = 8'hF7;
    localparam logic [7:0] STATUS_BIT     = 8'h80;
    localparam logic [7:0] DATA_MASK      = 8'h7F;
    localparam logic [7:0] HIGH_NIBBLE    = 8'hF0;
    localparam logic [7:0] NOTE_OFF       = 8'h80;
    localparam logic [7:0] NOTE_ON        = 8'h90;
    localparam logic [7:0] PROGRAM_CHANGE = 8'hC0;
    localparam logic [7:0] CHANNEL_PRESS  = 8'hD0;

    typedef struct packed {
        logic [7:0]  key;
        logic [7:0]  velocity;
        logic [31:0] start_tick;
        logic [31:0] length_ticks;
    } t_note;

endpackage

`default_nettype wire

// ===== hdl/mtne_parser.sv =====
`default_nettype none

module mtne_parser import mtne_pkg::*; #(
    parameter int TICK_BITS = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_take,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_eot,
    output logic            o_emit,
    output t_note           o_note
);

    typedef enum logic [6:0] {
        PH_DELTA    = 7'b0000001,
        PH_STATUS   = 7'b0000010,
        PH_METATYPE = 7'b0000100,
        PH_LENGTH   = 7'b0001000,
        PH_SKIP     = 7'b0010000,
        PH_DATA1    = 7'b0100000,
        PH_DATA2    = 7'b1000000
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic [31:0]            r_acc, n_acc;
    logic [TICK_BITS-1:0]   r_tick, n_tick;
    logic [7:0]             r_status, n_status;
    logic [31:0]            r_skip, n_skip;
    logic [7:0]             r_first, n_first;
    logic [7:0]             r_held_key, n_held_key;
    logic [7:0]             r_held_vel, n_held_vel;
    logic [TICK_BITS-1:0]   r_held_start, n_held_start;
    logic                   r_held_valid, n_held_valid;

    logic [31:0]            vlq_shift;
    logic                   vlq_done;
    logic [7:0]             kind;
    logic                   one_data;
    logic [TICK_BITS-1:0]   elapsed;

    assign vlq_shift = {r_acc[24:0], i_byte[6:0] & DATA_MASK[6:0]};
    assign vlq_done  = (i_byte & STATUS_BIT) == 8'h00;
    assign kind      = r_status & HIGH_NIBBLE;
    assign one_data  = (kind == PROGRAM_CHANGE) || (kind == CHANNEL_PRESS);
    assign elapsed   = r_tick - r_held_start;

    always_comb begin
        n_phase      = r_phase;
        n_acc        = r_acc;
        n_tick       = r_tick;
        n_status     = r_status;
        n_skip       = r_skip;
        n_first      = r_first;
        n_held_key   = r_held_key;
        n_held_vel   = r_held_vel;
        n_held_start = r_held_start;
        n_held_valid = r_held_valid;
        o_emit       = 1'b0;
        o_note.key          = r_held_key;
        o_note.velocity     = r_held_vel;
        o_note.start_tick   = 32'(r_held_start);
        o_note.length_ticks = 32'(elapsed);

        unique case (r_phase)
            PH_DELTA: begin
                n_acc = vlq_shift;
                if (vlq_done) begin
                    n_tick  = r_tick + TICK_BITS'(vlq_shift);
                    n_acc   = '0;
                    n_phase = PH_STATUS;
                end
            end
            PH_STATUS: begin
                if (i_byte == META_STATUS) begin
                    n_phase = PH_METATYPE;
                end else if (i_byte == SYSEX_START || i_byte == SYSEX_ESCAPE) begin
                    n_acc   = '0;
                    n_phase = PH_LENGTH;
                end else if ((i_byte & STATUS_BIT) != 8'h00) begin
                    n_status = i_byte;
                    n_phase  = PH_DATA1;
                end else begin
                    n_first = i_byte;
                    n_phase = one_data ? PH_DELTA : PH_DATA2;
                end
            end
            PH_METATYPE: begin
                n_acc   = '0;
                n_phase = PH_LENGTH;
            end
            PH_LENGTH: begin
                n_acc = vlq_shift;
                if (vlq_done) begin
                    n_skip  = vlq_shift;
                    n_acc   = '0;
                    n_phase = (vlq_shift != '0) ? PH_SKIP : PH_DELTA;
                end
            end
            PH_SKIP: begin
                n_skip = r_skip - 32'd1;
                if (n_skip == '0) begin
                    n_phase = PH_DELTA;
                end
            end
            PH_DATA1: begin
                n_first = i_byte;
                n_phase = one_data ? PH_DELTA : PH_DATA2;
            end
            PH_DATA2: begin
                n_phase = PH_DELTA;
                if (kind == NOTE_ON && i_byte != 8'h00) begin
                    n_held_key   = r_first;
                    n_held_vel   = i_byte;
                    n_held_start = r_tick;
                    n_held_valid = 1'b1;
                end else if ((kind == NOTE_OFF || kind == NOTE_ON) && r_held_valid) begin
                    o_emit       = i_take;
                    n_held_valid = 1'b0;
                end
            end
            default: begin
                n_phase = PH_DELTA;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_eot)) begin
            r_phase      <= PH_DELTA;
            r_acc        <= '0;
            r_tick       <= '0;
            r_status     <= '0;
            r_skip       <= '0;
            r_first      <= '0;
            r_held_key   <= '0;
            r_held_vel   <= '0;
            r_held_start <= '0;
            r_held_valid <= 1'b0;
        end else if (i_take) begin
            r_phase      <= n_phase;
            r_acc        <= n_acc;
            r_tick       <= n_tick;
            r_status     <= n_status;
            r_skip       <= n_skip;
            r_first      <= n_first;
            r_held_key   <= n_held_key;
            r_held_vel   <= n_held_vel;
            r_held_start <= n_held_start;
            r_held_valid <= n_held_valid;
        end
    end

    a_skip_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_SKIP |-> r_skip != '0)
        else $error("skip phase entered with nothing left to skip");

    a_emit_needs_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |-> r_phase == PH_DATA2 && r_held_valid)
        else $error("note emitted without a pending note");

    a_eot_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && i_eot |=> r_phase == PH_DELTA && !r_held_valid && r_tick == '0)
        else $error("end of track did not return the parser to reset");

endmodule

`default_nettype wire

// ===== hdl/midi_track_note_extractor.sv =====
// Channel   Handshake                 Payload
// input     i_valid / o_stall         i_data_byte, i_end_of_track
// output    o_valid / i_stall         o_note_key, o_note_velocity, o_start_tick,
//                                     o_length_ticks
//
// One byte is taken per cycle unless the output stalls; an item passes an input
// register, the parser's state update and a result register, so a result is offered
// from the result register. The parser state loop is a single registered step per byte.
// Reset is synchronous and clears the parser, which starts by expecting a delta time.
// A stalled result holds the result register, and the input register fills behind it.
`default_nettype none

module midi_track_note_extractor import mtne_pkg::*; #(
    parameter int TICK_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_end_of_track,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_note_key,
    output logic [7:0]       o_note_velocity,
    output logic [31:0]      o_start_tick,
    output logic [31:0]      o_length_ticks
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eot;
    logic       r_out_valid;
    t_note      r_out;
    logic       advance;
    logic       emit;
    t_note      note;

    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;

    mtne_parser #(
        .TICK_BITS(TICK_BITS)
    ) u_parser (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_take (advance),
        .i_byte (r_in_byte),
        .i_eot  (r_in_eot),
        .o_emit (emit),
        .o_note (note)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_data_byte;
            r_in_eot  <= i_end_of_track;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= emit;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out <= note;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_note_key      = r_out.key;
    assign o_note_velocity = r_out.velocity;
    assign o_start_tick    = r_out.start_tick;
    assign o_length_ticks  = r_out.length_ticks;

    a_stall_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid && r_out_valid && i_stall)
        else $error("input stalled without a blocked result");

    a_held_item_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> r_in_valid && $stable(r_in_byte) && $stable(r_in_eot))
        else $error("stalled input item was lost or changed");

    a_emit_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && emit |=> r_out_valid)
        else $error("emitted note did not reach the result register");

endmodule

`default_nettype wire
